// ===== rtl/vlfs_pkg.sv =====
// Package: shared types and constants for the video line/field sync tracker
`timescale 1ns / 1ps
package vlfs_pkg;

  localparam int unsigned DEF_LINES_PER_FRAME  = 625;
  localparam int unsigned DEF_VSYNC_LINE_COUNT = 5;

  localparam logic [2:0] REG_SYNC_LEVEL   = 3'd0;
  localparam logic [2:0] REG_LINE_LENGTH  = 3'd1;
  localparam logic [2:0] REG_LINE_FRAC    = 3'd2;
  localparam logic [2:0] REG_TIP_LENGTH   = 3'd3;
  localparam logic [2:0] REG_FWIN_START   = 3'd4;
  localparam logic [2:0] REG_FWIN_END     = 3'd5;
  localparam logic [2:0] REG_VWIN_SHIFT   = 3'd6;
  localparam logic [2:0] REG_SYNC_ENABLES = 3'd7;

  localparam int unsigned DIV_STEPS = 24;

  // divide by five: floor(a * RECIP5 / 2^22) is exact for a below 2^22
  localparam logic [19:0] RECIP5 = 20'd838861;

  typedef struct packed {
    logic start;
    logic div_step;
    logic err_load;
    logic steer;
    logic finish;
  } vlfs_cmd_t;

  typedef struct packed {
    logic edge_hit;
  } vlfs_status_t;

endpackage

// ===== rtl/vlfs_ctrl.sv =====
// Controller: sequences acceptance, edge division and result hand-off
`timescale 1ns / 1ps
module vlfs_ctrl
  import vlfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  vlfs_status_t status,
  output vlfs_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_ERR   = 6'b000100,
    ST_STEER = 6'b001000,
    ST_LINE  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [4:0] count, count_next;

  assign in_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    state_next = state;
    count_next = count;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = ST_DIV;
          count_next = '0;
        end
      end
      ST_DIV: begin
        if (!status.edge_hit) begin
          state_next = ST_ERR;
        end else begin
          cmd.div_step = 1'b1;
          count_next = count + 5'd1;
          if (count == 5'(DIV_STEPS - 1)) state_next = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.err_load = 1'b1;
        state_next = ST_STEER;
      end
      ST_STEER: begin
        cmd.steer = 1'b1;
        state_next = ST_LINE;
      end
      ST_LINE: begin
        cmd.finish = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

// ===== rtl/vlfs_datapath.sv =====
// Datapath: edge division, phase steering, window counters and line/field state
`timescale 1ns / 1ps
module vlfs_datapath
  import vlfs_pkg::*;
#(
  parameter int unsigned LINES_PER_FRAME  = DEF_LINES_PER_FRAME,
  parameter int unsigned VSYNC_LINE_COUNT = DEF_VSYNC_LINE_COUNT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_en,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic signed [15:0]  sample_in,
  input  vlfs_cmd_t           cmd,
  output vlfs_status_t        status,
  output logic [31:0]         result
);

  logic signed [15:0] sync_level;
  logic [11:0] line_length;
  logic [7:0]  line_frac;
  logic [9:0]  tip_length;
  logic [11:0] fwin_start, fwin_end;
  logic [10:0] vwin_shift;
  logic [1:0]  sync_enables;

  logic signed [15:0] previous_sample, cur;
  logic [11:0] since_edge;
  logic signed [12:0] offset_whole;
  logic signed [8:0]  offset_fraction;
  logic signed [20:0] pending_shift;
  logic signed [20:0] err_q;
  logic [2:0]  large_errors;
  logic [11:0] field_low, vsync_low;
  logic [9:0]  line_counter;
  logic        field_flag, phase_flag;
  logic        edge_hit;

  logic [23:0] quo;
  logic [17:0] divisor;
  logic [24:0] rem;
  logic        neg_num;
  logic line_end_r, frame_ready_r, found_r;

  logic [24:0] rem_shift;
  logic [25:0] rem_trial;
  assign rem_shift = {rem[23:0], quo[23]};
  assign rem_trial = {1'b0, rem_shift} - {8'd0, divisor};

  logic signed [17:0] ds_diff;
  logic signed [17:0] edge_gap;
  assign ds_diff = 18'(sample_in) - 18'(sync_level);
  assign edge_gap = 18'(signed'({1'b0, since_edge})) - 18'(signed'({6'd0, line_length}))
                    + 18'(signed'({8'd0, tip_length}));

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_level <= '0; line_length <= 12'd1024; line_frac <= '0; tip_length <= 10'd75;
      fwin_start <= '0; fwin_end <= '0; vwin_shift <= 11'd512; sync_enables <= 2'd3;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_SYNC_LEVEL:   sync_level <= cfg_data;
        REG_LINE_LENGTH:  line_length <= cfg_data[11:0];
        REG_LINE_FRAC:    line_frac <= cfg_data[7:0];
        REG_TIP_LENGTH:   tip_length <= cfg_data[9:0];
        REG_FWIN_START:   fwin_start <= cfg_data[11:0];
        REG_FWIN_END:     fwin_end <= cfg_data[11:0];
        REG_VWIN_SHIFT:   vwin_shift <= cfg_data[10:0];
        REG_SYNC_ENABLES: sync_enables <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // edge error: wrap once by the line length, then saturate
  logic signed [8:0]  frac_s;
  logic signed [23:0] err0, err1, half, lw;
  logic signed [20:0] errc;

  always_comb begin
    frac_s = neg_num ? -$signed({1'b0, quo[7:0]}) : $signed({1'b0, quo[7:0]});
    err0 = -(24'($signed({offset_whole, 8'd0})) + 24'(offset_fraction)) - 24'(frac_s);
    half = 24'($signed({1'b0, line_length[11:1], 8'd0}));
    lw = 24'($signed({1'b0, line_length, 8'd0}));
    err1 = err0;
    if (err0 > half) err1 = err0 - lw;
    else if (err0 < -half) err1 = err0 + lw;
    if (err1 > 24'sd1048575) errc = {1'b0, {20{1'b1}}};
    else if (err1 < -24'sd1048576) errc = {1'b1, 20'd0};
    else errc = err1[20:0];
  end

  // steering: damp by one fifth or jump after repeated large errors
  logic [20:0] abs_err;
  logic [40:0] prod5;
  logic [20:0] mag5;
  logic signed [20:0] shift5, ps_steer;
  logic [2:0] le_next, le_inc;
  logic [11:0] se_next;

  always_comb begin
    abs_err = err_q[20] ? 21'(-err_q) : 21'(err_q);
    prod5 = 41'(abs_err) * 41'(RECIP5);
    mag5 = {2'b00, prod5[40:22]};
    shift5 = err_q[20] ? -$signed(mag5) : $signed(mag5);
    ps_steer = pending_shift;
    le_next = large_errors;
    se_next = since_edge;
    le_inc = large_errors + 3'd1;
    if (sync_enables[0]) begin
      if (edge_hit) begin
        if (abs_err > 21'({tip_length, 8'd0})) begin
          le_next = le_inc;
          if (le_inc >= 3'd4) begin
            ps_steer = err_q;
            le_next = '0;
          end
        end else begin
          ps_steer = shift5;
          le_next = '0;
        end
        se_next = '0;
      end else if (since_edge != 12'hFFF) begin
        se_next = since_edge + 12'd1;
      end
    end
  end

  // line stage
  logic signed [23:0] nv, nvc;
  logic signed [13:0] ow_inc;
  logic signed [12:0] ow_fin;
  logic line_done;
  logic [12:0] len;
  logic signed [14:0] owx, fs, fe, fsh, feh;
  logic [11:0] fl_next, vl_next;
  logic [9:0] lc1, lc_fin;
  logic ff_fin, fr;
  logic signed [8:0] of_fin;
  logic low;

  always_comb begin
    ow_inc = 14'(offset_whole) + 14'sd1;
    line_done = ow_inc >= $signed({2'b00, line_length});
    low = cur < sync_level;
    owx = 15'(ow_inc);
    fs = 15'(signed'({1'b0, fwin_start}));
    fe = 15'(signed'({1'b0, fwin_end}));
    fsh = fs + 15'(signed'({1'b0, vwin_shift}));
    feh = fe + 15'(signed'({1'b0, vwin_shift}));
    fl_next = field_low;
    vl_next = vsync_low;
    if (sync_enables[1]) begin
      if (low && owx > fs && owx < fe && field_low != 12'hFFF) fl_next = field_low + 12'd1;
      if (low && owx > fsh && owx < feh && vsync_low != 12'hFFF) vl_next = vsync_low + 12'd1;
    end
    len = (fwin_end >= fwin_start) ? 13'(fwin_end - fwin_start) : 13'd0;
    nv = 24'(pending_shift) + 24'(offset_fraction) - 24'($signed({1'b0, line_frac}));
    if (nv > 24'sd1048575) nvc = 24'sd1048575;
    else if (nv < -24'sd1048575) nvc = -24'sd1048575;
    else nvc = nv;
    ow_fin = 13'(ow_inc);
    of_fin = offset_fraction;
    lc_fin = line_counter;
    ff_fin = field_flag;
    fr = 1'b0;
    lc1 = line_counter + 10'd1;
    if (line_done) begin
      ow_fin = 13'(nvc / 256);
      of_fin = 9'(nvc % 256);
      lc_fin = lc1;
      if (lc1 == 10'(VSYNC_LINE_COUNT + 3) && !field_flag) fr = 1'b1;
      if (sync_enables[1] && 13'(vl_next) > (len >> 1) &&
          (lc1 < 10'd3 || lc1 > 10'(VSYNC_LINE_COUNT + 1))) begin
        if (15'(fl_next) > 15'((15'(len) * 15'd3) >> 2)) ff_fin = 1'b0;
        else if (13'(fl_next) < (len >> 2)) ff_fin = 1'b1;
        lc_fin = 10'd2;
      end
      fl_next = '0;
      vl_next = '0;
      if (11'(lc_fin) > 11'(LINES_PER_FRAME / 2) + 11'(ff_fin)) begin
        lc_fin = 10'd1;
        ff_fin = ~ff_fin;
      end
    end
  end

  assign status.edge_hit = edge_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0; since_edge <= '0; offset_whole <= '0; offset_fraction <= '0;
      pending_shift <= '0; large_errors <= '0; field_low <= '0; vsync_low <= '0;
      line_counter <= '0; field_flag <= 1'b0; phase_flag <= 1'b0; err_q <= '0;
      line_end_r <= 1'b0; frame_ready_r <= 1'b0; found_r <= 1'b0; edge_hit <= 1'b0;
    end else begin
      if (cmd.start) begin
        cur <= sample_in;
        edge_hit <= sync_enables[0] && previous_sample >= sync_level &&
                    sample_in < sync_level && edge_gap > 18'sd0;
        neg_num <= ds_diff < 0;
        quo <= {(ds_diff < 0 ? 16'(-ds_diff) : 16'(ds_diff)), 8'd0};
        divisor <= 18'(previous_sample) - 18'(sample_in);
        rem <= '0;
      end
      if (cmd.div_step) begin
        if (!rem_trial[25]) begin
          rem <= rem_trial[24:0];
          quo <= {quo[22:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[22:0], 1'b0};
        end
      end
      if (cmd.err_load) err_q <= errc;
      if (cmd.steer) begin
        since_edge <= se_next; large_errors <= le_next; pending_shift <= ps_steer;
      end
      if (cmd.finish) begin
        offset_whole <= ow_fin; offset_fraction <= of_fin;
        field_low <= fl_next; vsync_low <= vl_next;
        line_counter <= lc_fin; field_flag <= ff_fin;
        line_end_r <= line_done;
        if (line_done) begin
          pending_shift <= '0;
          phase_flag <= ~phase_flag;
        end
        frame_ready_r <= fr;
        found_r <= sync_enables[0] && edge_hit;
        previous_sample <= cur;
      end
    end
  end

  assign result = {4'd0, offset_whole, found_r, phase_flag, frame_ready_r, field_flag,
                   line_counter, line_end_r};

endmodule

// ===== rtl/video_line_field_sync_tracker.sv =====
// Top level: video line and field sync tracker
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one signed Q2.13 video sample per request in tdata[15:0].
//   m_axis returns one result per sample in tdata[27:0]:
//     line_end, line_number[9:0], field_number, frame_ready, chroma_invert,
//     sync_found, line_offset[12:0], lowest bit first.
//   Configuration: cfg_en/cfg_index/cfg_data write one register per cycle;
//   write only while the block is idle.
// Timing:
//   A sample without a sync edge passes through DIV, ERR, STEER and LINE to result valid.
//   A sample with a falling sync edge runs a restoring divider, one quotient
//   bit per cycle for 24 bits, before the ERR, STEER and LINE states.
//   One sample is in flight at a time; the next is taken once the result leaves.
// Reset: rst clears all tracking state and loads register defaults.
// Stall: while m_axis_tready is low the result holds and s_axis_tready stays low.
module video_line_field_sync_tracker
  import vlfs_pkg::*;
#(
  parameter int unsigned LINES_PER_FRAME  = DEF_LINES_PER_FRAME,
  parameter int unsigned VSYNC_LINE_COUNT = DEF_VSYNC_LINE_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample[15:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // line_end, line_number, field_number, frame_ready,
                                      // chroma_invert, sync_found, line_offset
  input  logic        cfg_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  vlfs_cmd_t    cmd;
  vlfs_status_t status;

  vlfs_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .status(status), .cmd(cmd)
  );

  vlfs_datapath #(
    .LINES_PER_FRAME(LINES_PER_FRAME), .VSYNC_LINE_COUNT(VSYNC_LINE_COUNT)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_in(s_axis_tdata), .cmd(cmd), .status(status), .result(m_axis_tdata)
  );

endmodule
